// ----- sv/aq_pkg.sv -----
`timescale 1ns / 1ps

package aq_pkg;

    // Ring depth and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the channels.
    localparam int SEQ_W  = 64;
    localparam int PAY_W  = 64;
    localparam int ID_W   = 16;
    localparam int DROP_W = 32;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Operation codes carried by the kind field.
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_PUBLISH = 2'd1,
        OP_ACK     = 2'd2,
        OP_RETRY   = 2'd3
    } aq_op_t;

    // One accepted input item.
    typedef struct packed {
        logic [1:0]        kind;
        logic [SEQ_W-1:0]  seq_number;
        logic [PAY_W-1:0]  payload_word;
        logic signed [ID_W:0] msg_id;
    } aq_item_t;

    // One result item.
    typedef struct packed {
        logic              accepted;
        logic              head_valid;
        logic              head_in_flight;
        logic [SEQ_W-1:0]  head_seq;
        logic [PAY_W-1:0]  head_payload;
        logic [ID_W-1:0]   head_msg_id;
        cnt_t              entry_count;
        logic [DROP_W-1:0] drop_total;
    } aq_result_t;

    // Write request from the control logic to the entry store.
    typedef struct packed {
        logic             we;
        ptr_t             addr;
        logic [SEQ_W-1:0] seq;
        logic [PAY_W-1:0] pay;
    } aq_wr_t;

    // Next slot around the ring.
    function automatic ptr_t ring_next(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(CAPACITY - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Slot that lies n entries past p, with n at most CAPACITY.
    function automatic ptr_t ring_add(input ptr_t p, input cnt_t n);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(p) + (CNT_W + 1)'(n);
        if (s >= (CNT_W + 1)'(CAPACITY))
        begin
            s = s - (CNT_W + 1)'(CAPACITY);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

// ----- sv/aq_in_if.sv -----
`timescale 1ns / 1ps

interface aq_in_if;

    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [aq_pkg::SEQ_W-1:0]    seq_number;
    logic [aq_pkg::PAY_W-1:0]    payload_word;
    logic signed [aq_pkg::ID_W:0] msg_id;

    modport source (output valid, output kind, output seq_number, output payload_word,
                    output msg_id, input ready);
    modport sink   (input valid, input kind, input seq_number, input payload_word,
                    input msg_id, output ready);

endinterface

// ----- sv/aq_out_if.sv -----
`timescale 1ns / 1ps

interface aq_out_if;

    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic                        head_valid;
    logic                        head_in_flight;
    logic [aq_pkg::SEQ_W-1:0]    head_seq;
    logic [aq_pkg::PAY_W-1:0]    head_payload;
    logic [aq_pkg::ID_W-1:0]     head_msg_id;
    logic [aq_pkg::CNT_W-1:0]    entry_count;
    logic [aq_pkg::DROP_W-1:0]   drop_total;

    modport source (output valid, output accepted, output head_valid, output head_in_flight,
                    output head_seq, output head_payload, output head_msg_id,
                    output entry_count, output drop_total, input ready);
    modport sink   (input valid, input accepted, input head_valid, input head_in_flight,
                    input head_seq, input head_payload, input head_msg_id,
                    input entry_count, input drop_total, output ready);

endinterface

// ----- sv/aq_store.sv -----
`timescale 1ns / 1ps

// Entry register file: one write port, one read port for the slot after the head.
module aq_store (
    input  logic                     clk,
    input  aq_pkg::aq_wr_t           wr,
    input  aq_pkg::ptr_t             rd_addr,
    output logic [aq_pkg::SEQ_W-1:0] rd_seq,
    output logic [aq_pkg::PAY_W-1:0] rd_pay
);

    logic [aq_pkg::SEQ_W-1:0] seq_mem [aq_pkg::CAPACITY];
    logic [aq_pkg::PAY_W-1:0] pay_mem [aq_pkg::CAPACITY];

    // Contents are undefined until written, so the array has no reset.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            seq_mem[wr.addr] <= wr.seq;
            pay_mem[wr.addr] <= wr.pay;
        end
    end

    // The slot after the head becomes the new head when the head leaves.
    assign rd_seq = seq_mem[rd_addr];
    assign rd_pay = pay_mem[rd_addr];

endmodule

// ----- sv/aq_ctrl.sv -----
`timescale 1ns / 1ps

// Queue control: pointers, fill count, in-flight mark, drop counter and a
// copy of the head entry. The head copy lets an in-flight head move one slot
// forward without a second write into the store.
module aq_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  aq_pkg::aq_item_t         item,
    input  logic [aq_pkg::SEQ_W-1:0] rd_seq,
    input  logic [aq_pkg::PAY_W-1:0] rd_pay,
    output aq_pkg::ptr_t             rd_addr,
    output aq_pkg::aq_wr_t           wr,
    output aq_pkg::aq_result_t       result
);

    aq_pkg::ptr_t              head_ptr_reg, head_ptr_next;
    aq_pkg::cnt_t              fill_reg, fill_next;
    logic                      busy_reg, busy_next;
    logic [aq_pkg::ID_W-1:0]   busy_id_reg, busy_id_next;
    logic [aq_pkg::DROP_W-1:0] drop_reg, drop_next;
    logic [aq_pkg::SEQ_W-1:0]  hd_seq_reg, hd_seq_next;
    logic [aq_pkg::PAY_W-1:0]  hd_pay_reg, hd_pay_next;

    aq_pkg::aq_op_t            op;
    aq_pkg::ptr_t              head_adv;
    logic                      full;
    logic                      nonempty;
    logic                      id_neg;
    logic [aq_pkg::ID_W-1:0]   id16;
    logic                      ok;
    logic                      valid_after;

    assign op       = aq_pkg::aq_op_t'(item.kind);
    assign head_adv = aq_pkg::ring_next(head_ptr_reg);
    assign full     = (fill_reg == aq_pkg::CNT_W'(aq_pkg::CAPACITY));
    assign nonempty = (fill_reg != '0);
    assign id_neg   = item.msg_id[aq_pkg::ID_W];
    assign id16     = item.msg_id[aq_pkg::ID_W-1:0];
    assign rd_addr  = head_adv;

    // Next state for the item in the input register.
    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        fill_next     = fill_reg;
        busy_next     = busy_reg;
        busy_id_next  = busy_id_reg;
        drop_next     = drop_reg;
        hd_seq_next   = hd_seq_reg;
        hd_pay_next   = hd_pay_reg;
        ok            = 1'b0;
        wr.we         = 1'b0;
        wr.addr       = aq_pkg::ring_add(head_ptr_reg, fill_reg);
        wr.seq        = item.seq_number;
        wr.pay        = item.payload_word;

        unique case (op)
            aq_pkg::OP_PUSH:
            begin
                if (full)
                begin
                    drop_next = drop_reg + aq_pkg::DROP_W'(1);
                    if (busy_reg && aq_pkg::CAPACITY == 1)
                    begin
                        // The single slot is in flight: the new entry is lost.
                        ok = 1'b0;
                    end
                    else
                    begin
                        // Drop one entry; the new tail lands on the old head slot.
                        ok            = 1'b1;
                        head_ptr_next = head_adv;
                        wr.we         = 1'b1;
                        wr.addr       = head_ptr_reg;
                        if (!busy_reg)
                        begin
                            if (aq_pkg::CAPACITY == 1)
                            begin
                                hd_seq_next = item.seq_number;
                                hd_pay_next = item.payload_word;
                            end
                            else
                            begin
                                hd_seq_next = rd_seq;
                                hd_pay_next = rd_pay;
                            end
                        end
                    end
                end
                else
                begin
                    ok        = 1'b1;
                    wr.we     = 1'b1;
                    fill_next = fill_reg + aq_pkg::CNT_W'(1);
                    if (!nonempty)
                    begin
                        hd_seq_next = item.seq_number;
                        hd_pay_next = item.payload_word;
                    end
                end
            end
            aq_pkg::OP_PUBLISH:
            begin
                if (nonempty && !busy_reg && !id_neg)
                begin
                    ok           = 1'b1;
                    busy_next    = 1'b1;
                    busy_id_next = id16;
                end
            end
            aq_pkg::OP_ACK:
            begin
                if (nonempty && busy_reg && !id_neg && busy_id_reg == id16)
                begin
                    ok            = 1'b1;
                    busy_next     = 1'b0;
                    busy_id_next  = '0;
                    head_ptr_next = head_adv;
                    fill_next     = fill_reg - aq_pkg::CNT_W'(1);
                    hd_seq_next   = rd_seq;
                    hd_pay_next   = rd_pay;
                end
            end
            aq_pkg::OP_RETRY:
            begin
                if (nonempty)
                begin
                    ok           = 1'b1;
                    busy_next    = 1'b0;
                    busy_id_next = '0;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        wr.we = wr.we & fire;
    end

    // Result as seen after the step.
    assign valid_after           = (fill_next != '0);
    assign result.accepted       = ok;
    assign result.head_valid     = valid_after;
    assign result.head_in_flight = valid_after & busy_next;
    assign result.head_seq       = valid_after ? hd_seq_next : '0;
    assign result.head_payload   = valid_after ? hd_pay_next : '0;
    assign result.head_msg_id    = (valid_after && busy_next) ? busy_id_next : '0;
    assign result.entry_count    = fill_next;
    assign result.drop_total     = drop_next;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg <= '0;
            fill_reg     <= '0;
            busy_reg     <= 1'b0;
            busy_id_reg  <= '0;
            drop_reg     <= '0;
        end
        else if (fire)
        begin
            head_ptr_reg <= head_ptr_next;
            fill_reg     <= fill_next;
            busy_reg     <= busy_next;
            busy_id_reg  <= busy_id_next;
            drop_reg     <= drop_next;
        end
    end

    // Head entry copy; only read while the queue holds entries.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hd_seq_reg <= hd_seq_next;
            hd_pay_reg <= hd_pay_next;
        end
    end

endmodule

// ----- sv/ack_queue_with_drop_oldest.sv -----
`timescale 1ns / 1ps
// A result passes the input register and the queue logic into the result register, then is offered.
// One item per cycle unless rsp stalls; input register, one pass of queue logic, result register.
// A stalled result holds the pass, and the input register takes one more item behind it.
// Reset clears pointers, fill count, in-flight mark, drop count and both valid flags.
// Entry storage is not cleared; entries are never read before they are written.
module ack_queue_with_drop_oldest (
    input logic     clk,
    input logic     rst_n,
    aq_in_if.sink   req,
    aq_out_if.source rsp
);

    logic               stage_valid_reg;
    aq_pkg::aq_item_t   stage_item_reg;
    logic               out_valid_reg;
    aq_pkg::aq_result_t out_reg;
    logic               fire;
    aq_pkg::aq_result_t result;
    aq_pkg::aq_wr_t     wr;
    aq_pkg::ptr_t       rd_addr;
    logic [aq_pkg::SEQ_W-1:0] rd_seq;
    logic [aq_pkg::PAY_W-1:0] rd_pay;

    // The queue step runs when an item waits and the result register is free.
    assign fire      = stage_valid_reg & (~out_valid_reg | rsp.ready);
    assign req.ready = ~stage_valid_reg | fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            stage_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            stage_item_reg.kind         <= req.kind;
            stage_item_reg.seq_number   <= req.seq_number;
            stage_item_reg.payload_word <= req.payload_word;
            stage_item_reg.msg_id       <= req.msg_id;
        end
    end

    aq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (stage_item_reg),
        .rd_seq  (rd_seq),
        .rd_pay  (rd_pay),
        .rd_addr (rd_addr),
        .wr      (wr),
        .result  (result)
    );

    aq_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_seq  (rd_seq),
        .rd_pay  (rd_pay)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.accepted       = out_reg.accepted;
    assign rsp.head_valid     = out_reg.head_valid;
    assign rsp.head_in_flight = out_reg.head_in_flight;
    assign rsp.head_seq       = out_reg.head_seq;
    assign rsp.head_payload   = out_reg.head_payload;
    assign rsp.head_msg_id    = out_reg.head_msg_id;
    assign rsp.entry_count    = out_reg.entry_count;
    assign rsp.drop_total     = out_reg.drop_total;

endmodule

// ----- sv/aq_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks on the result channel.
module aq_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      accepted,
    input logic                      head_valid,
    input logic                      head_in_flight,
    input logic [aq_pkg::SEQ_W-1:0]  head_seq,
    input logic [aq_pkg::ID_W-1:0]   head_msg_id,
    input logic [aq_pkg::CNT_W-1:0]  entry_count,
    input logic [aq_pkg::DROP_W-1:0] drop_total
);

    // A stalled result holds its values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_count) && $stable(drop_total)
            && $stable(accepted))
        else $error("stalled result changed");

    // An empty queue shows zero head fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_valid |-> entry_count == '0 && head_seq == '0 && head_msg_id == '0
            && !head_in_flight)
        else $error("empty queue shows head data");

    // A non-empty queue reports a count within capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && head_valid |-> entry_count != '0
            && entry_count <= aq_pkg::CNT_W'(aq_pkg::CAPACITY))
        else $error("entry count out of range");

    // Only an in-flight head carries a message id.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_in_flight |-> head_msg_id == '0)
        else $error("message id without in-flight head");

endmodule

bind ack_queue_with_drop_oldest aq_checker u_aq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .accepted       (rsp.accepted),
    .head_valid     (rsp.head_valid),
    .head_in_flight (rsp.head_in_flight),
    .head_seq       (rsp.head_seq),
    .head_msg_id    (rsp.head_msg_id),
    .entry_count    (rsp.entry_count),
    .drop_total     (rsp.drop_total)
);

// ----- tb/sv/ack_queue_with_drop_oldest_test.sv -----
`timescale 1ns / 1ps

module ack_queue_with_drop_oldest_test;

    import aq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic signed [ID_W:0] ID_NEG  = -17'sd1;
    localparam logic signed [ID_W:0] ID_ZERO = 17'sd0;
    localparam logic signed [ID_W:0] ID_TOP  = 17'sd65535;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;

    aq_in_if  req_if();
    aq_out_if rsp_if();

    ack_queue_with_drop_oldest DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the queue, advanced on every accepted input transfer.
    logic [SEQ_W-1:0]  ring_seq [CAPACITY];
    logic [PAY_W-1:0]  ring_pay [CAPACITY];
    int                ring_head;
    int                ring_fill;
    logic              head_pub;
    logic [ID_W-1:0]   pub_id;
    logic [DROP_W-1:0] dropped;

    aq_result_t expected_heads[$];

    bit steady;
    int fail_count;
    int cycle_count;
    int items_sent;
    int results_checked;
    int pushes_stored;
    int acks_done;
    int full_pushes;

    // Free-running clock, 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Global watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout at %0t after %0d cycles", $time, cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side back-pressure; no stalls while steady is set.
    always @(negedge clk)
    begin
        rsp_if.ready <= steady || ($urandom_range(99) >= 37);
    end

    // Apply one input item to the shadow queue and return the expected result.
    function automatic aq_result_t advance_queue(input aq_item_t it);
        aq_result_t res;
        logic       ok;
        int         slot;
        ok = 1'b0;
        case (aq_op_t'(it.kind))
            OP_PUSH:
            begin
                ok = 1'b1;
                if (ring_fill >= CAPACITY)
                begin
                    full_pushes++;
                    if (head_pub)
                    begin
                        if (CAPACITY == 1)
                        begin
                            ok = 1'b0;
                        end
                        else
                        begin
                            // The in-flight head moves onto the entry after it.
                            slot = (ring_head + 1) % CAPACITY;
                            ring_seq[slot] = ring_seq[ring_head];
                            ring_pay[slot] = ring_pay[ring_head];
                            ring_head = slot;
                            ring_fill--;
                        end
                    end
                    else
                    begin
                        ring_head = (ring_head + 1) % CAPACITY;
                        ring_fill--;
                    end
                    dropped = dropped + 1'b1;
                end
                if (ok)
                begin
                    slot = (ring_head + ring_fill) % CAPACITY;
                    ring_seq[slot] = it.seq_number;
                    ring_pay[slot] = it.payload_word;
                    ring_fill++;
                    pushes_stored++;
                end
            end
            OP_PUBLISH:
            begin
                if (ring_fill != 0 && !head_pub && !it.msg_id[ID_W])
                begin
                    head_pub = 1'b1;
                    pub_id   = it.msg_id[ID_W-1:0];
                    ok       = 1'b1;
                end
            end
            OP_ACK:
            begin
                if (ring_fill != 0 && head_pub && !it.msg_id[ID_W]
                    && pub_id == it.msg_id[ID_W-1:0])
                begin
                    head_pub  = 1'b0;
                    pub_id    = '0;
                    ring_head = (ring_head + 1) % CAPACITY;
                    ring_fill--;
                    ok        = 1'b1;
                    acks_done++;
                end
            end
            default:
            begin
                if (ring_fill != 0)
                begin
                    head_pub = 1'b0;
                    pub_id   = '0;
                    ok       = 1'b1;
                end
            end
        endcase

        res.accepted       = ok;
        res.head_valid     = (ring_fill != 0);
        res.head_in_flight = (ring_fill != 0) && head_pub;
        res.head_seq       = (ring_fill != 0) ? ring_seq[ring_head] : '0;
        res.head_payload   = (ring_fill != 0) ? ring_pay[ring_head] : '0;
        res.head_msg_id    = ((ring_fill != 0) && head_pub) ? pub_id : '0;
        res.entry_count    = cnt_t'(ring_fill);
        res.drop_total     = dropped;
        return res;
    endfunction

    function automatic aq_item_t make_item(input aq_op_t op, input logic [63:0] seq,
                                           input logic [63:0] pay,
                                           input logic signed [ID_W:0] id);
        aq_item_t it;
        it.kind         = op;
        it.seq_number   = seq;
        it.payload_word = pay;
        it.msg_id       = id;
        return it;
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        case ($urandom_range(9))
            0: w = '0;
            1: w = ALL_ONES;
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    function automatic logic signed [ID_W:0] rand_id();
        logic signed [ID_W:0] id;
        case ($urandom_range(19))
            0: id = ID_ZERO;
            1: id = ID_TOP;
            default: id = {1'b0, 16'($urandom_range(65535))};
        endcase
        return id;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        aq_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_heads.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual entry_count %0d",
                         $time, rsp_if.entry_count);
                fail_count++;
            end
            else
            begin
                want = expected_heads.pop_front();
                check_field("accepted", want.accepted, rsp_if.accepted);
                check_field("head_valid", want.head_valid, rsp_if.head_valid);
                check_field("head_in_flight", want.head_in_flight, rsp_if.head_in_flight);
                check_field("head_seq", want.head_seq, rsp_if.head_seq);
                check_field("head_payload", want.head_payload, rsp_if.head_payload);
                check_field("head_msg_id", want.head_msg_id, rsp_if.head_msg_id);
                check_field("entry_count", want.entry_count, rsp_if.entry_count);
                check_field("drop_total", want.drop_total, rsp_if.drop_total);
                results_checked++;
            end
        end
    end

    // Offer one item and hold it until the transfer; returns at the following falling edge.
    task automatic send_item(input aq_item_t it);
        while (!steady && $urandom_range(99) < 37)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.kind         <= it.kind;
        req_if.seq_number   <= it.seq_number;
        req_if.payload_word <= it.payload_word;
        req_if.msg_id       <= it.msg_id;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        expected_heads.push_back(advance_queue(it));
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        @(negedge clk);
        while (expected_heads.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Pushes with random content until the shadow queue is full.
    task automatic fill_queue();
        while (ring_fill < CAPACITY)
        begin
            send_item(make_item(OP_PUSH, rand_word(), rand_word(), rand_id()));
        end
    endtask

    // Empty-queue rejections, field extremes, publish/ack/retry rules.
    task automatic test_directed_ops();
        send_item(make_item(OP_PUBLISH, '0, '0, ID_ZERO));
        send_item(make_item(OP_ACK, '0, '0, ID_ZERO));
        send_item(make_item(OP_RETRY, ALL_ONES, ALL_ONES, ID_NEG));
        send_item(make_item(OP_PUSH, ALL_ONES, ALL_ONES, ID_TOP));
        send_item(make_item(OP_PUSH, '0, '0, ID_NEG));
        // A negative id is refused by publish.
        send_item(make_item(OP_PUBLISH, '0, '0, ID_NEG));
        send_item(make_item(OP_PUBLISH, '0, '0, ID_TOP));
        // A second publish on an in-flight head is refused.
        send_item(make_item(OP_PUBLISH, '0, '0, ID_ZERO));
        send_item(make_item(OP_ACK, '0, '0, 17'sd1234));
        // Same low bits as the in-flight id, but negative.
        send_item(make_item(OP_ACK, '0, '0, ID_NEG));
        send_item(make_item(OP_RETRY, '0, '0, ID_ZERO));
        // Ack on a head that is no longer in flight.
        send_item(make_item(OP_ACK, '0, '0, ID_TOP));
        send_item(make_item(OP_PUBLISH, '0, '0, ID_ZERO));
        send_item(make_item(OP_ACK, '0, '0, ID_ZERO));
        send_item(make_item(OP_RETRY, '0, '0, ID_ZERO));
        send_item(make_item(OP_PUBLISH, '0, '0, 17'sd21845));
        send_item(make_item(OP_ACK, ALL_ONES, ALL_ONES, 17'sd21845));
        wait_for_results();
    endtask

    // Overflow with an idle head, then with an in-flight head.
    task automatic test_overflow();
        if (head_pub)
        begin
            send_item(make_item(OP_RETRY, '0, '0, ID_ZERO));
        end
        fill_queue();
        send_item(make_item(OP_PUSH, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, ID_ZERO));
        send_item(make_item(OP_PUBLISH, '0, '0, 17'sd4660));
        send_item(make_item(OP_PUSH, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, ID_ZERO));
        send_item(make_item(OP_PUSH, ALL_ONES, '0, ID_ZERO));
        send_item(make_item(OP_ACK, '0, '0, 17'sd4660));
        wait_for_results();
    endtask

    // Mixed traffic: mostly well-formed publish/ack cycles, some refused requests.
    task automatic run_traffic(input int count);
        int push_pct;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            // Vary the push share so the queue swings between empty and full.
            if (n % 64 == 0)
            begin
                push_pct = $urandom_range(20, 75);
            end
            // Now and then hold the sender until the queue has answered everything.
            if (n % 150 == 149)
            begin
                wait_for_results();
            end
            pick = $urandom_range(99);
            if (pick < push_pct || ring_fill == 0 && pick < 90)
            begin
                send_item(make_item(OP_PUSH, rand_word(), rand_word(), rand_id()));
            end
            else
            begin
                pick = $urandom_range(99);
                if (head_pub)
                begin
                    if (pick < 70)
                        send_item(make_item(OP_ACK, rand_word(), rand_word(), {1'b0, pub_id}));
                    else if (pick < 80)
                        send_item(make_item(OP_ACK, '0, '0, {1'b0, pub_id + 16'd1}));
                    else if (pick < 88)
                        send_item(make_item(OP_RETRY, rand_word(), rand_word(), rand_id()));
                    else if (pick < 94)
                        send_item(make_item(OP_PUBLISH, '0, '0, rand_id()));
                    else
                        send_item(make_item(OP_ACK, '0, '0, ID_NEG));
                end
                else
                begin
                    if (pick < 75)
                        send_item(make_item(OP_PUBLISH, rand_word(), rand_word(), rand_id()));
                    else if (pick < 85)
                        send_item(make_item(OP_RETRY, '0, '0, rand_id()));
                    else if (pick < 92)
                        send_item(make_item(OP_ACK, '0, '0, rand_id()));
                    else
                        send_item(make_item(OP_PUBLISH, '0, '0, ID_NEG));
                end
            end
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        run_traffic(1100);
    endtask

    // Full rate on both sides, no random idle cycles and no stalls.
    task automatic test_back_to_back();
        steady = 1'b1;
        run_traffic(300);
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        clk                 = 1'b0;
        req_if.valid        = 1'b0;
        req_if.kind         = OP_PUSH;
        req_if.seq_number   = '0;
        req_if.payload_word = '0;
        req_if.msg_id       = '0;
        rsp_if.ready        = 1'b0;
        steady              = 1'b0;
        fail_count          = 0;
        cycle_count         = 0;
        items_sent          = 0;
        results_checked     = 0;
        pushes_stored       = 0;
        acks_done           = 0;
        full_pushes         = 0;
        ring_head           = 0;
        ring_fill           = 0;
        head_pub            = 1'b0;
        pub_id              = '0;
        dropped             = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            ring_seq[i] = '0;
            ring_pay[i] = '0;
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_ops();
        test_overflow();
        test_random_traffic();
        test_back_to_back();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d items and %0d checked results: %0d stored pushes, %0d acks.",
                 items_sent, results_checked, pushes_stored, acks_done);
        $display("Pushes into a full queue: %0d, drop count at end: %0d.",
                 full_pushes, dropped);
        if (fail_count == 0 && expected_heads.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     fail_count, expected_heads.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
